>>> design/tcc_pkg.sv
// Shared constants, types and address helpers for the text console cursor engine.
// Depends on nothing; used by the top level, the cell RAM and the port checker.
package tcc_pkg;

    // Screen geometry
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TAB_WIDTH = 8;
    localparam int CELLS     = COLUMNS * ROWS;

    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(CELLS);

    // Tab stops: smallest multiple of TAB_WIDTH at or above COLUMNS bounds the search
    localparam int TAB_STOPS = (COLUMNS + TAB_WIDTH - 1) / TAB_WIDTH;
    localparam int TCOL_W    = $clog2(TAB_STOPS * TAB_WIDTH + 1);

    // Field widths at the ports
    localparam int ROW_PORT_W = 5;
    localparam int COL_PORT_W = 7;
    localparam int LOC_PORT_W = 11;
    localparam int CELL_W     = 16;

    // Character codes
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TOP       = 8'h7F;

    localparam logic [7:0] RESET_ATTR = 8'h0F;

    // Request modes
    localparam logic [1:0] MODE_PUT   = 2'd0;
    localparam logic [1:0] MODE_CLEAR = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_FILL
    } tcc_state_t;

    // Linear cell address of a row and column
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        cell_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

    // Reduce a sum of two row numbers below ROWS
    function automatic logic [ROW_W-1:0] row_wrap(input logic [ROW_W:0] sum);
        row_wrap = (sum >= (ROW_W+1)'(ROWS)) ? ROW_W'(sum - (ROW_W+1)'(ROWS))
                                            : ROW_W'(sum);
    endfunction

    // Next tab stop strictly after col; independent compares against constants
    function automatic logic [TCOL_W-1:0] tab_stop(input logic [COL_W-1:0] col);
        logic [TCOL_W-1:0] stop;
        stop = TCOL_W'(TAB_STOPS * TAB_WIDTH);
        for (int k = TAB_STOPS; k >= 1; k--)
        begin
            if (TCOL_W'(k * TAB_WIDTH) > TCOL_W'(col))
            begin
                stop = TCOL_W'(k * TAB_WIDTH);
            end
        end
        tab_stop = stop;
    endfunction

endpackage

>>> design/tcc_cell_ram.sv
// Screen cell buffer: one write port, one read port, registered read data.
// Depends on tcc_pkg for depth and widths.
module tcc_cell_ram
    import tcc_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [CELL_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem [CELLS];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> design/text_console_cursor_engine.sv
// Text console: 80x25 cell buffer in a RAM, cursor control and scrolling.
// Depends on tcc_pkg and tcc_cell_ram.
// Clear, control codes and puts into written rows: done in the cycle after accept, if no scroll.
// Reads pass ST_READ first. A printable put into a row untouched since clear/reset, or a scroll,
// sweeps a row in ST_FILL (both: two rows), one RAM write per cycle; results cannot be held off.
// Reset: cursor home, all rows read as blanks with attribute 0x0F, no RAM sweep needed.
module text_console_cursor_engine
    import tcc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            mode,
    input  logic [7:0]            char_code,
    input  logic [3:0]            bg_color,
    input  logic [3:0]            fg_color,
    input  logic [4:0]            read_row,
    input  logic [6:0]            read_col,
    input  logic                  cfg_we,
    input  logic [7:0]            cfg_data,
    output logic                  done,
    output logic [ROW_PORT_W-1:0] cursor_row,
    output logic [COL_PORT_W-1:0] cursor_col,
    output logic [LOC_PORT_W-1:0] cursor_location,
    output logic [CELL_W-1:0]     cell_value
);

    tcc_state_t state_reg, state_next;

    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  top_reg, top_next;          // physical row shown as row 0
    logic [ROWS-1:0]   row_valid_reg, row_valid_next;
    logic [7:0]        clear_attr_reg, clear_attr_next;
    logic [7:0]        blank_attr_reg;

    logic [ROW_W-1:0]  fill_phys_reg, fill_phys_next;
    logic [COL_W-1:0]  fill_col_reg, fill_col_next;
    logic [CELL_W-1:0] fill_blank_reg, fill_blank_next;
    logic              has_char_reg, has_char_next;
    logic [COL_W-1:0]  char_col_reg, char_col_next;
    logic [CELL_W-1:0] char_word_reg, char_word_next;
    logic              scroll_pend_reg, scroll_pend_next;
    logic              rd_valid_reg, rd_valid_next;

    logic              done_reg, done_next;
    logic [CELL_W-1:0] cell_reg, cell_next;
    logic [ROW_W-1:0]  out_row_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ADDR_W-1:0] out_loc_reg;

    // RAM port
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    // Put-mode cursor arithmetic
    logic [TCOL_W-1:0] adv_col;
    logic [ROW_W:0]    adv_row;
    logic              printable;
    logic              wrap_col;
    logic              need_scroll;
    logic [ROW_W-1:0]  put_row;
    logic [COL_W-1:0]  put_col;
    logic [ROW_W-1:0]  cur_phys;
    logic [ROW_W-1:0]  rd_phys;
    logic              rd_in_range;
    logic [CELL_W-1:0] put_word;
    logic              fill_last;

    tcc_cell_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blank_attr_reg <= RESET_ATTR;
        end
        else if (cfg_we)
        begin
            blank_attr_reg <= cfg_data;
        end
    end

    // Cursor movement for one put byte
    always_comb
    begin
        printable = (char_code >= CH_SPACE) && (char_code <= CH_TOP);
        adv_col   = TCOL_W'(col_reg);
        adv_row   = (ROW_W+1)'(row_reg);
        case (char_code)
            CH_BACKSPACE:
            begin
                if (col_reg != '0)
                begin
                    adv_col = TCOL_W'(col_reg) - TCOL_W'(1);
                end
            end
            CH_TAB:
            begin
                adv_col = tab_stop(col_reg);
            end
            CH_CR:
            begin
                adv_col = '0;
            end
            CH_LF:
            begin
                adv_col = '0;
                adv_row = (ROW_W+1)'(row_reg) + (ROW_W+1)'(1);
            end
            default:
            begin
                if (printable)
                begin
                    adv_col = TCOL_W'(col_reg) + TCOL_W'(1);
                end
            end
        endcase

        wrap_col = (adv_col >= TCOL_W'(COLUMNS));
        if (wrap_col)
        begin
            adv_row = adv_row + (ROW_W+1)'(1);
        end
        need_scroll = (adv_row >= (ROW_W+1)'(ROWS));
        put_col     = wrap_col ? '0 : COL_W'(adv_col);
        put_row     = need_scroll ? ROW_W'(ROWS - 1) : ROW_W'(adv_row);

        cur_phys    = row_wrap((ROW_W+1)'(top_reg) + (ROW_W+1)'(row_reg));
        rd_in_range = (read_row < 5'(ROWS)) && (read_col < 7'(COLUMNS));
        rd_phys     = row_wrap((ROW_W+1)'(top_reg) + (ROW_W+1)'(ROW_W'(read_row)));
        put_word    = {bg_color, fg_color, char_code};
        fill_last   = (fill_col_reg == COL_W'(COLUMNS - 1));
    end

    // Control state machine: next state, RAM access, result
    always_comb
    begin
        state_next       = state_reg;
        row_next         = row_reg;
        col_next         = col_reg;
        top_next         = top_reg;
        row_valid_next   = row_valid_reg;
        clear_attr_next  = clear_attr_reg;
        fill_phys_next   = fill_phys_reg;
        fill_col_next    = fill_col_reg;
        fill_blank_next  = fill_blank_reg;
        has_char_next    = has_char_reg;
        char_col_next    = char_col_reg;
        char_word_next   = char_word_reg;
        scroll_pend_next = scroll_pend_reg;
        rd_valid_next    = rd_valid_reg;
        done_next        = 1'b0;
        cell_next        = '0;

        ram_we    = 1'b0;
        ram_waddr = cell_addr(fill_phys_reg, fill_col_reg);
        ram_wdata = fill_blank_reg;
        ram_raddr = cell_addr(rd_phys, COL_W'(read_col));

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (mode)
                        MODE_PUT:
                        begin
                            row_next = put_row;
                            col_next = put_col;
                            if (printable && !row_valid_reg[cur_phys])
                            begin
                                // untouched row: sweep it, dropping the char in place
                                state_next       = ST_FILL;
                                fill_phys_next   = cur_phys;
                                fill_col_next    = '0;
                                fill_blank_next  = {clear_attr_reg, CH_SPACE};
                                has_char_next    = 1'b1;
                                char_col_next    = col_reg;
                                char_word_next   = put_word;
                                scroll_pend_next = need_scroll;
                            end
                            else
                            begin
                                if (printable)
                                begin
                                    ram_we    = 1'b1;
                                    ram_waddr = cell_addr(cur_phys, col_reg);
                                    ram_wdata = put_word;
                                end
                                if (need_scroll)
                                begin
                                    // old top row becomes the new bottom row
                                    state_next       = ST_FILL;
                                    fill_phys_next   = top_reg;
                                    top_next         = row_wrap((ROW_W+1)'(top_reg)
                                                                + (ROW_W+1)'(1));
                                    fill_col_next    = '0;
                                    fill_blank_next  = {blank_attr_reg, CH_SPACE};
                                    has_char_next    = 1'b0;
                                    scroll_pend_next = 1'b0;
                                end
                                else
                                begin
                                    done_next = 1'b1;
                                end
                            end
                        end
                        MODE_CLEAR:
                        begin
                            row_next        = '0;
                            col_next        = '0;
                            top_next        = '0;
                            row_valid_next  = '0;
                            clear_attr_next = blank_attr_reg;
                            done_next       = 1'b1;
                        end
                        MODE_READ:
                        begin
                            if (rd_in_range)
                            begin
                                state_next    = ST_READ;
                                rd_valid_next = row_valid_reg[rd_phys];
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
                done_next  = 1'b1;
                cell_next  = rd_valid_reg ? ram_rdata : {clear_attr_reg, CH_SPACE};
            end
            ST_FILL:
            begin
                ram_we = 1'b1;
                if (has_char_reg && (fill_col_reg == char_col_reg))
                begin
                    ram_wdata = char_word_reg;
                end
                fill_col_next = fill_col_reg + COL_W'(1);
                if (fill_last)
                begin
                    row_valid_next[fill_phys_reg] = 1'b1;
                    if (scroll_pend_reg)
                    begin
                        fill_phys_next   = top_reg;
                        top_next         = row_wrap((ROW_W+1)'(top_reg) + (ROW_W+1)'(1));
                        fill_col_next    = '0;
                        fill_blank_next  = {blank_attr_reg, CH_SPACE};
                        has_char_next    = 1'b0;
                        scroll_pend_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                        done_next  = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            row_reg         <= '0;
            col_reg         <= '0;
            top_reg         <= '0;
            row_valid_reg   <= '0;
            clear_attr_reg  <= RESET_ATTR;
            has_char_reg    <= 1'b0;
            scroll_pend_reg <= 1'b0;
            rd_valid_reg    <= 1'b0;
            fill_col_reg    <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            row_reg         <= row_next;
            col_reg         <= col_next;
            top_reg         <= top_next;
            row_valid_reg   <= row_valid_next;
            clear_attr_reg  <= clear_attr_next;
            has_char_reg    <= has_char_next;
            scroll_pend_reg <= scroll_pend_next;
            rd_valid_reg    <= rd_valid_next;
            fill_col_reg    <= fill_col_next;
            done_reg        <= done_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        fill_phys_reg  <= fill_phys_next;
        fill_blank_reg <= fill_blank_next;
        char_col_reg   <= char_col_next;
        char_word_reg  <= char_word_next;
        if (done_next)
        begin
            out_row_reg <= row_next;
            out_col_reg <= col_next;
            out_loc_reg <= cell_addr(row_next, col_next);
            cell_reg    <= cell_next;
        end
    end

    assign busy            = (state_reg != ST_IDLE);
    assign done            = done_reg;
    assign cursor_row      = ROW_PORT_W'(out_row_reg);
    assign cursor_col      = COL_PORT_W'(out_col_reg);
    assign cursor_location = LOC_PORT_W'(out_loc_reg);
    assign cell_value      = cell_reg;

endmodule

>>> design/tcc_checker.sv
// Port-level checks for the text console cursor engine, bound to the top level.
// Depends on tcc_pkg and sees only the top-level ports.
module tcc_checker
    import tcc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input logic [ROW_PORT_W-1:0] cursor_row,
    input logic [COL_PORT_W-1:0] cursor_col,
    input logic [LOC_PORT_W-1:0] cursor_location
);

    // A result is only given as the engine goes idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // An accepted request either finishes at once or keeps the engine busy
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> (busy || done))
        else $error("accepted request neither finished nor in progress");

    // Reported cursor stays on screen
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((cursor_row < ROW_PORT_W'(ROWS)) && (cursor_col < COL_PORT_W'(COLUMNS))))
        else $error("cursor off screen");

    // Location register agrees with row and column
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (cursor_location == LOC_PORT_W'(LOC_PORT_W'(cursor_row) * LOC_PORT_W'(COLUMNS)
                                                  + LOC_PORT_W'(cursor_col))))
        else $error("cursor location mismatch");

endmodule

bind text_console_cursor_engine tcc_checker u_tcc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .cursor_row      (cursor_row),
    .cursor_col      (cursor_col),
    .cursor_location (cursor_location)
);

>>> test/text_console_cursor_engine_test.sv
// Self-checking bench for text_console_cursor_engine: directed and random console requests,
// a request-level model of the screen and cursor, and a check of every done result.
// Depends on tcc_pkg and the design files only.
module text_console_cursor_engine_test;
    import tcc_pkg::*;

    localparam logic [1:0] MODE_NONE   = 2'd3;
    localparam int         CYCLE_LIMIT = 2_000_000;
    localparam int         REPORT_MAX  = 10;
    localparam int         LF_SPARSE   = 3;
    localparam int         LF_DENSE    = 30;

    typedef struct packed {
        logic       hold;
        logic [1:0] mode;
        logic [7:0] char_code;
        logic [3:0] bg_color;
        logic [3:0] fg_color;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } console_req_t;

    typedef struct packed {
        logic [ROW_PORT_W-1:0] row;
        logic [COL_PORT_W-1:0] col;
        logic [LOC_PORT_W-1:0] loc;
        logic [CELL_W-1:0]     cell_data;
    } cursor_report_t;

    logic                  clk;
    logic                  rst_n      = 1'b0;
    logic                  start      = 1'b0;
    logic                  busy;
    logic [1:0]            mode       = '0;
    logic [7:0]            char_code  = '0;
    logic [3:0]            bg_color   = '0;
    logic [3:0]            fg_color   = '0;
    logic [4:0]            read_row   = '0;
    logic [6:0]            read_col   = '0;
    logic                  cfg_we     = 1'b0;
    logic [7:0]            cfg_data   = '0;
    logic                  done;
    logic [ROW_PORT_W-1:0] cursor_row;
    logic [COL_PORT_W-1:0] cursor_col;
    logic [LOC_PORT_W-1:0] cursor_location;
    logic [CELL_W-1:0]     cell_value;

    // Screen and cursor as the block should hold them
    logic [CELL_W-1:0] screen_img [CELLS];
    int                cur_row;
    int                cur_col;
    logic [7:0]        blank_attr;

    console_req_t   console_requests [$];
    cursor_report_t reports_due [$];
    console_req_t   live_req;
    cursor_report_t due;
    cursor_report_t seen;
    int             gap_left;
    int             calm_left;
    logic           launch;
    int             mismatch_count = 0;
    int             cycle_count = 0;

    text_console_cursor_engine i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .mode            (mode),
        .char_code       (char_code),
        .bg_color        (bg_color),
        .fg_color        (fg_color),
        .read_row        (read_row),
        .read_col        (read_col),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .done            (done),
        .cursor_row      (cursor_row),
        .cursor_col      (cursor_col),
        .cursor_location (cursor_location),
        .cell_value      (cell_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [CELL_W-1:0] blank_word();
        return {blank_attr, CH_SPACE};
    endfunction

    // Apply one accepted request to the screen image and queue the cursor report it causes
    task automatic advance_console(input console_req_t r);
        cursor_report_t rep;
        rep.cell_data = '0;
        case (r.mode)
            MODE_PUT:
            begin
                if (r.char_code == CH_BACKSPACE)
                begin
                    if (cur_col > 0)
                        cur_col--;
                end
                else if (r.char_code == CH_TAB)
                    cur_col = cur_col + TAB_WIDTH - (cur_col % TAB_WIDTH);
                else if (r.char_code == CH_CR)
                    cur_col = 0;
                else if (r.char_code == CH_LF)
                begin
                    cur_row++;
                    cur_col = 0;
                end
                else if (r.char_code >= CH_SPACE && r.char_code <= CH_TOP)
                begin
                    screen_img[cur_row * COLUMNS + cur_col] =
                        {r.bg_color, r.fg_color, r.char_code};
                    cur_col++;
                end
                if (cur_col >= COLUMNS)
                begin
                    cur_col = 0;
                    cur_row++;
                end
                // past the bottom row: scroll up and blank the new last row
                if (cur_row >= ROWS)
                begin
                    for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
                        screen_img[i] = screen_img[i + COLUMNS];
                    for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
                        screen_img[i] = blank_word();
                    cur_row = ROWS - 1;
                end
            end
            MODE_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                    screen_img[i] = blank_word();
                cur_row = 0;
                cur_col = 0;
            end
            MODE_READ:
            begin
                if (r.read_row < ROWS && r.read_col < COLUMNS)
                    rep.cell_data = screen_img[r.read_row * COLUMNS + r.read_col];
            end
            default:
            begin
                // unused mode: nothing moves
            end
        endcase
        rep.row = ROW_PORT_W'(cur_row);
        rep.col = COL_PORT_W'(cur_col);
        rep.loc = LOC_PORT_W'(cur_row * COLUMNS + cur_col);
        reports_due.push_back(rep);
    endtask

    function automatic console_req_t make_req(input logic [1:0] m, input logic [7:0] ch,
                                              input logic [3:0] bg, input logic [3:0] fg,
                                              input logic [4:0] rr, input logic [6:0] rc);
        console_req_t r;
        r.hold      = 1'b0;
        r.mode      = m;
        r.char_code = ch;
        r.bg_color  = bg;
        r.fg_color  = fg;
        r.read_row  = rr;
        r.read_col  = rc;
        return r;
    endfunction

    // Mostly text with some cursor controls; reads, clears and junk mixed in
    function automatic console_req_t random_request(input int lf_share);
        console_req_t r;
        int pick;
        int sub;
        r.hold      = ($urandom_range(0, 199) == 0);
        r.mode      = MODE_PUT;
        r.char_code = 8'($urandom);
        r.bg_color  = 4'($urandom);
        r.fg_color  = 4'($urandom);
        r.read_row  = 5'($urandom);
        r.read_col  = 7'($urandom);
        pick = $urandom_range(0, 999);
        if (pick < 5)
            r.mode = MODE_CLEAR;
        else if (pick < 25)
            r.mode = MODE_NONE;
        else if (pick < 175)
        begin
            r.mode = MODE_READ;
            if ($urandom_range(0, 9) != 0)
            begin
                r.read_row = 5'($urandom_range(0, ROWS - 1));
                r.read_col = 7'($urandom_range(0, COLUMNS - 1));
            end
        end
        else
        begin
            sub = $urandom_range(0, 99);
            if (sub < lf_share)
                r.char_code = CH_LF;
            else if (sub < lf_share + 4)
                r.char_code = CH_BACKSPACE;
            else if (sub < lf_share + 8)
                r.char_code = CH_TAB;
            else if (sub < lf_share + 11)
                r.char_code = CH_CR;
            else if (sub < lf_share + 14)
                r.char_code = $urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                                   : 8'($urandom_range(128, 255));
            else
                r.char_code = 8'($urandom_range(CH_SPACE, CH_TOP));
        end
        return r;
    endfunction

    task automatic wait_idle();
        while (console_requests.size() != 0 || start || busy || reports_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // New blank attribute, optional clear, then a batch of random requests
    task automatic run_phase(input logic [7:0] attr, input int count, input int lf_share);
        wait_idle();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= attr;
        @(posedge clk);
        cfg_we <= 1'b0;
        blank_attr = attr;
        if ($urandom_range(0, 1))
            console_requests.push_back(make_req(MODE_CLEAR, 8'($urandom), 4'($urandom),
                                                4'($urandom), 5'($urandom), 7'($urandom)));
        repeat (count)
            console_requests.push_back(random_request(lf_share));
    endtask

    // Request driver: issues queued requests with random gaps and calm stretches
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start     <= 1'b0;
            gap_left  = 0;
            calm_left = 0;
        end
        else
        begin
            if (start && !busy)
            begin
                advance_console(live_req);
                if (calm_left > 0)
                begin
                    calm_left--;
                    gap_left = 0;
                end
                else
                begin
                    gap_left = $urandom_range(0, 12);
                    if ($urandom_range(0, 40) == 0)
                        calm_left = $urandom_range(10, 60);
                end
            end
            if (!start || !busy)
            begin
                launch = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (console_requests.size() != 0 &&
                         !(console_requests[0].hold && reports_due.size() != 0))
                begin
                    live_req   = console_requests.pop_front();
                    mode      <= live_req.mode;
                    char_code <= live_req.char_code;
                    bg_color  <= live_req.bg_color;
                    fg_color  <= live_req.fg_color;
                    read_row  <= live_req.read_row;
                    read_col  <= live_req.read_col;
                    launch     = 1'b1;
                end
                start <= launch;
            end
        end
    end

    // Result monitor: every done pulse against the oldest queued report
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            seen = {cursor_row, cursor_col, cursor_location, cell_value};
            if (reports_due.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result: row %0d col %0d loc %0d cell %h",
                             seen.row, seen.col, seen.loc, seen.cell_data);
            end
            else
            begin
                due = reports_due.pop_front();
                if (seen.row !== due.row || seen.col !== due.col ||
                    seen.loc !== due.loc || seen.cell_data !== due.cell_data)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("mismatch: got row %0d col %0d loc %0d cell %h, %s",
                                 seen.row, seen.col, seen.loc, seen.cell_data,
                                 $sformatf("expected row %0d col %0d loc %0d cell %h",
                                           due.row, due.col, due.loc, due.cell_data));
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** text_console_cursor_engine: FAILED **");
            $finish;
        end
    end

    // Reset, directed requests, then random phases over several blank attributes
    initial
    begin
        blank_attr = RESET_ATTR;
        for (int i = 0; i < CELLS; i++)
            screen_img[i] = blank_word();
        cur_row = 0;
        cur_col = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset contents, reads off the screen, unused mode
        console_requests.push_back(make_req(MODE_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0));
        console_requests.push_back(make_req(MODE_READ, 8'hFF, 4'hF, 4'hF, 5'd24, 7'd79));
        console_requests.push_back(make_req(MODE_READ, 8'h00, 4'h0, 4'h0, 5'd25, 7'd5));
        console_requests.push_back(make_req(MODE_READ, 8'h00, 4'h0, 4'h0, 5'd3, 7'd80));
        console_requests.push_back(make_req(MODE_READ, 8'h00, 4'h0, 4'h0, 5'd31, 7'd127));
        console_requests.push_back(make_req(MODE_NONE, 8'h41, 4'hF, 4'hF, 5'd31, 7'd127));
        // printable extremes and color extremes
        console_requests.push_back(make_req(MODE_PUT, 8'h41, 4'hF, 4'hF, 5'd0, 7'd0));
        console_requests.push_back(make_req(MODE_PUT, CH_SPACE, 4'h0, 4'h0, 5'd0, 7'd0));
        console_requests.push_back(make_req(MODE_PUT, CH_TOP, 4'hA, 4'h5, 5'd0, 7'd0));
        // ignored bytes: low control codes and the upper half
        console_requests.push_back(make_req(MODE_PUT, 8'h1F, 4'h1, 4'h2, 5'd0, 7'd0));
        console_requests.push_back(make_req(MODE_PUT, 8'h00, 4'h1, 4'h2, 5'd0, 7'd0));
        console_requests.push_back(make_req(MODE_PUT, 8'h80, 4'h1, 4'h2, 5'd0, 7'd0));
        console_requests.push_back(make_req(MODE_PUT, 8'hFF, 4'h1, 4'h2, 5'd0, 7'd0));
        // cursor controls, backspace at column zero included
        console_requests.push_back(make_req(MODE_PUT, CH_BACKSPACE, 4'h0, 4'h0, 5'd0, 7'd0));
        console_requests.push_back(make_req(MODE_PUT, CH_CR, 4'h0, 4'h0, 5'd0, 7'd0));
        console_requests.push_back(make_req(MODE_PUT, CH_BACKSPACE, 4'h0, 4'h0, 5'd0, 7'd0));
        console_requests.push_back(make_req(MODE_PUT, CH_TAB, 4'h0, 4'h0, 5'd0, 7'd0));
        console_requests.push_back(make_req(MODE_PUT, CH_TAB, 4'h0, 4'h0, 5'd0, 7'd0));
        console_requests.push_back(make_req(MODE_PUT, CH_LF, 4'h0, 4'h0, 5'd0, 7'd0));
        console_requests.push_back(make_req(MODE_PUT, 8'h7E, 4'h3, 4'hC, 5'd0, 7'd0));
        console_requests.push_back(make_req(MODE_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0));
        console_requests.push_back(make_req(MODE_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd2));
        console_requests.push_back(make_req(MODE_CLEAR, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0));
        console_requests.push_back(make_req(MODE_READ, 8'h00, 4'h0, 4'h0, 5'd0, 7'd0));

        run_phase(8'h00, 315, LF_SPARSE);
        run_phase(8'hFF, 315, LF_DENSE);
        run_phase(8'($urandom), 315, LF_SPARSE);
        run_phase(8'hA5, 315, LF_DENSE);
        run_phase(8'($urandom), 315, LF_SPARSE);
        run_phase(8'h5A, 300, LF_SPARSE);

        wait_idle();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("** text_console_cursor_engine: PASSED **");
        else
            $display("** text_console_cursor_engine: FAILED **");
        $finish;
    end

endmodule

>>> text_console_cursor_engine.f
design/tcc_pkg.sv
design/tcc_cell_ram.sv
design/text_console_cursor_engine.sv
design/tcc_checker.sv
test/text_console_cursor_engine_test.sv
